[rtl/core/mws_pkg.sv]
// Package with shared types and constants of the mecanum wheel speed solver.
package mws_pkg;

    localparam int NumCells  = 15;          // one quotient bit per cell
    localparam int SpeedW    = 22;          // width of an unscaled wheel sum
    localparam int MagW      = 21;          // width of a wheel sum magnitude

    localparam logic [15:0] GeometrySumReset = 16'd2920;
    localparam logic [14:0] SpeedLimitReset  = 15'd3072;

    typedef enum logic [1:0] {
        REG_INVERT_SIDEWAYS = 2'd0,
        REG_INVERT_FORWARD  = 2'd1,
        REG_GEOMETRY_SUM    = 2'd2,
        REG_SPEED_LIMIT     = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic signed [15:0] sideways_velocity;
        logic signed [15:0] forward_velocity;
        logic signed [15:0] yaw_rate;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] front_left_speed;
        logic signed [15:0] front_right_speed;
        logic signed [15:0] back_left_speed;
        logic signed [15:0] back_right_speed;
        logic               was_scaled;
    } wheel_t;

    typedef struct packed {
        logic        invert_sideways;
        logic        invert_forward;
        logic [15:0] geometry_sum;
        logic [14:0] speed_limit;
    } cfg_t;

    // One wheel inside the divider chain.
    typedef struct packed {
        logic              neg;
        logic [MagW-1:0]   rem;
        logic [14:0]       dlo;
        logic [14:0]       quo;
        logic [15:0]       raw;
    } lane_t;

    typedef struct packed {
        lane_t [3:0]       lane;
        logic [MagW-1:0]   divisor;
        logic              scaled;
    } cell_t;

endpackage

[rtl/core/mws_front.sv]
// Front pipeline: sign inversion, rotation term, wheel sums, maximum and dividend products.
module mws_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             in_valid,
    input  mws_pkg::cmd_t    in_cmd,
    input  mws_pkg::cfg_t    cfg,
    output logic             out_valid,
    output mws_pkg::cell_t   out_cell
);
    import mws_pkg::*;

    function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
        return (v == 16'sh8000) ? 16'sh7fff : -v;
    endfunction

    logic                     v1_reg, v2_reg, v3_reg;
    logic signed [15:0]       vx1_reg, vy1_reg, vx1_next, vy1_next;
    logic signed [32:0]       prod1_reg, prod1_next;
    logic signed [SpeedW-1:0] sp2_reg [4];
    logic signed [SpeedW-1:0] sp2_next [4];
    logic signed [32:0]       kround;
    logic signed [SpeedW-1:0] k2, vx22, vy22;
    logic [MagW-1:0]          mag [4];
    logic [MagW-1:0]          mx01, mx23, mx;
    logic [35:0]              prod3 [4];
    cell_t                    cell3_reg, cell3_next;

    always_comb begin
        vx1_next   = cfg.invert_sideways ? neg_sat(in_cmd.sideways_velocity)
                                         : in_cmd.sideways_velocity;
        vy1_next   = cfg.invert_forward ? neg_sat(in_cmd.forward_velocity)
                                        : in_cmd.forward_velocity;
        prod1_next = $signed({1'b0, cfg.geometry_sum}) * 33'(in_cmd.yaw_rate);
    end

    // Division by 4096 truncating toward zero.
    always_comb begin
        kround = (prod1_reg + (prod1_reg[32] ? 33'sd4095 : 33'sd0)) >>> 12;
        k2     = SpeedW'(kround);
        vx22   = SpeedW'(vx1_reg);
        vy22   = SpeedW'(vy1_reg);
        sp2_next[0] = vy22 + vx22 - k2;
        sp2_next[1] = vy22 - vx22 + k2;
        sp2_next[2] = vy22 - vx22 - k2;
        sp2_next[3] = vy22 + vx22 + k2;
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            mag[i]   = sp2_reg[i][SpeedW-1] ? MagW'(-sp2_reg[i]) : MagW'(sp2_reg[i]);
            prod3[i] = 36'(mag[i]) * 36'(cfg.speed_limit);
        end
        mx01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
        mx23 = (mag[2] > mag[3]) ? mag[2] : mag[3];
        mx   = (mx01 > mx23) ? mx01 : mx23;
        cell3_next.divisor = mx;
        cell3_next.scaled  = mx > MagW'(cfg.speed_limit);
        for (int i = 0; i < 4; i++) begin
            cell3_next.lane[i].neg = sp2_reg[i][SpeedW-1];
            cell3_next.lane[i].rem = prod3[i][35:15];
            cell3_next.lane[i].dlo = prod3[i][14:0];
            cell3_next.lane[i].quo = '0;
            cell3_next.lane[i].raw = sp2_reg[i][15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            vx1_reg   <= vx1_next;
            vy1_reg   <= vy1_next;
            prod1_reg <= prod1_next;
            sp2_reg   <= sp2_next;
            cell3_reg <= cell3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_cell  = cell3_reg;

endmodule

[rtl/core/mws_div_cell.sv]
// One restoring division cell: produces one quotient bit for each of the four wheels.
module mws_div_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_valid,
    input  mws_pkg::cell_t  in_cell,
    output logic            out_valid,
    output mws_pkg::cell_t  out_cell
);
    import mws_pkg::*;

    logic          valid_reg;
    cell_t         cell_reg, cell_next;
    logic [MagW:0] trial [4];

    always_comb begin
        cell_next = in_cell;
        for (int i = 0; i < 4; i++) begin
            trial[i] = {in_cell.lane[i].rem, in_cell.lane[i].dlo[14]};
            cell_next.lane[i].dlo = {in_cell.lane[i].dlo[13:0], 1'b0};
            if (trial[i] >= {1'b0, in_cell.divisor}) begin
                cell_next.lane[i].rem = MagW'(trial[i] - {1'b0, in_cell.divisor});
                cell_next.lane[i].quo = {in_cell.lane[i].quo[13:0], 1'b1};
            end else begin
                cell_next.lane[i].rem = MagW'(trial[i]);
                cell_next.lane[i].quo = {in_cell.lane[i].quo[13:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cell_reg <= cell_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_cell  = cell_reg;

endmodule

[rtl/core/mecanum_wheel_speed_solver_top.sv]
// Top level of the mecanum wheel speed solver: config registers, pipeline and output register.
//
// The solver turns one chassis velocity command beat into one beat of four wheel
// speeds. It accepts a new command every clock cycle while the result side keeps
// taking results. Three front stages apply the sign inversions, form the rotation
// term and wheel sums, and find the largest wheel magnitude. Then a row of 15
// division cells, one quotient bit per cell, scales the wheels by limit/max when
// the largest magnitude exceeds the limit, truncating toward zero. A final output
// register holds the result beat. The whole pipeline advances together: it moves
// whenever the output register is empty or being taken, so a stalled result holds
// every command behind it. Configuration writes take effect at once and should
// only be made while no command is in flight.
module mecanum_wheel_speed_solver_top (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  mws_pkg::cmd_t    s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output mws_pkg::wheel_t  m_payload
);
    import mws_pkg::*;

    cfg_t   cfg_reg;
    logic   adv;
    logic   chain_valid [NumCells+1];
    cell_t  chain_cell  [NumCells+1];
    logic   m_valid_reg;
    wheel_t m_payload_reg, m_payload_next;
    cell_t  last;

    // Configuration registers; an index is written whenever the enable is high.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.invert_sideways <= 1'b0;
            cfg_reg.invert_forward  <= 1'b0;
            cfg_reg.geometry_sum    <= GeometrySumReset;
            cfg_reg.speed_limit     <= SpeedLimitReset;
        end else if (cfg_wr_en) begin
            unique case (reg_index_t'(cfg_index))
                REG_INVERT_SIDEWAYS: cfg_reg.invert_sideways <= cfg_wdata[0];
                REG_INVERT_FORWARD:  cfg_reg.invert_forward  <= cfg_wdata[0];
                REG_GEOMETRY_SUM:    cfg_reg.geometry_sum    <= cfg_wdata;
                REG_SPEED_LIMIT:     cfg_reg.speed_limit     <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves when the output register is free or its beat is taken.
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    mws_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_cmd    (s_payload),
        .cfg       (cfg_reg),
        .out_valid (chain_valid[0]),
        .out_cell  (chain_cell[0])
    );

    for (genvar g = 0; g < NumCells; g++) begin : g_cell
        mws_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (chain_valid[g]),
            .in_cell   (chain_cell[g]),
            .out_valid (chain_valid[g+1]),
            .out_cell  (chain_cell[g+1])
        );
    end

    // The quotient is a magnitude; the wheel's sign is put back here. Unscaled
    // wheels already fit in 16 bits because they are within the limit.
    assign last = chain_cell[NumCells];

    always_comb begin
        logic [15:0] q [4];
        for (int i = 0; i < 4; i++) begin
            if (last.scaled) begin
                q[i] = last.lane[i].neg ? -{1'b0, last.lane[i].quo}
                                        : {1'b0, last.lane[i].quo};
            end else begin
                q[i] = last.lane[i].raw;
            end
        end
        m_payload_next.front_left_speed  = q[0];
        m_payload_next.front_right_speed = q[1];
        m_payload_next.back_left_speed   = q[2];
        m_payload_next.back_right_speed  = q[3];
        m_payload_next.was_scaled        = last.scaled;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= chain_valid[NumCells];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_payload_reg <= m_payload_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

[rtl/core/mws_checker.sv]
// Port checker of the mecanum wheel speed solver and its bind to the top level.
module mws_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input mws_pkg::wheel_t  m_payload
);
    import mws_pkg::*;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat shown right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("stalled result beat changed");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("command taken while pipeline is stalled");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_payload.front_left_speed != 16'sh8000
                 && m_payload.front_right_speed != 16'sh8000
                 && m_payload.back_left_speed != 16'sh8000
                 && m_payload.back_right_speed != 16'sh8000)
        else $error("wheel speed out of range");

endmodule

bind mecanum_wheel_speed_solver_top mws_checker u_mws_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

[verif/tb_mecanum_wheel_speed_solver_top.sv]
// Self-checking testbench for the mecanum wheel speed solver top level.
module tb_mecanum_wheel_speed_solver_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mws_pkg::*;

    // Settle margin after draining, well above the acceptance-to-result latency.
    localparam int SettleCycles = 40;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    cmd_t        s_payload = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    wheel_t      m_payload;

    mecanum_wheel_speed_solver_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #1 aclk = ~aclk;

    // The predictor keeps its own copy of the register file.
    cfg_t   solver_cfg;
    cmd_t   pending_cmds[$];
    wheel_t expected_wheels[$];
    int     mismatch_count = 0;
    int     beats_sent = 0;
    int     beats_checked = 0;
    int     scaled_seen = 0;
    bit     sender_hold = 1'b0;
    bit     s_taken = 1'b0;
    int     send_gap = 0;
    int     take_gap = 0;

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Saturating negate of a 16-bit command; the most negative value becomes +32767.
    function automatic int negate_sat(int v);
        return (v == -32768) ? 32767 : -v;
    endfunction

    function automatic wheel_t solve_wheels(cmd_t c);
        wheel_t    w;
        int        vx, vy, k, peak, mag;
        int        spd[4];
        longint    prod;
        vx = int'(c.sideways_velocity);
        vy = int'(c.forward_velocity);
        if (solver_cfg.invert_sideways) vx = negate_sat(vx);
        if (solver_cfg.invert_forward) vy = negate_sat(vy);
        // SystemVerilog division truncates toward zero, as the hardware does.
        prod = longint'(solver_cfg.geometry_sum) * longint'(int'(c.yaw_rate));
        k = int'(prod / 64'sd4096);
        spd[0] = vy + vx - k;
        spd[1] = vy - vx + k;
        spd[2] = vy - vx - k;
        spd[3] = vy + vx + k;
        peak = 0;
        for (int i = 0; i < 4; i++) begin
            mag = (spd[i] < 0) ? -spd[i] : spd[i];
            if (mag > peak) peak = mag;
        end
        w.was_scaled = (peak > int'(solver_cfg.speed_limit));
        if (w.was_scaled) begin
            for (int i = 0; i < 4; i++) begin
                spd[i] = int'((longint'(spd[i]) * longint'(solver_cfg.speed_limit))
                              / longint'(peak));
            end
        end
        w.front_left_speed  = spd[0][15:0];
        w.front_right_speed = spd[1][15:0];
        w.back_left_speed   = spd[2][15:0];
        w.back_right_speed  = spd[3][15:0];
        return w;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at beat %0d: %s got %0d expected %0d", beats_checked, what, got, want);
        mismatch_count++;
    endtask

    // Driver: offers queued commands at the falling edge, with random gaps between beats.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_taken) begin
            // The beat was taken at the last rising edge; keep valid high only for a new beat.
            if (pending_cmds.size() > 0 && !sender_hold && gap_length() == 0) begin
                s_payload <= pending_cmds.pop_front();
            end else begin
                s_valid <= 1'b0;
                send_gap <= gap_length();
            end
        end else if (!s_valid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_cmds.size() > 0 && !sender_hold) begin
                s_valid <= 1'b1;
                s_payload <= pending_cmds.pop_front();
            end
        end
    end

    // Result side stalls at random too.
    always @(negedge aclk) begin
        if (take_gap > 0) begin
            m_ready <= 1'b0;
            take_gap <= take_gap - 1;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 9) < 3) take_gap <= gap_length();
        end
    end

    // Monitor: predicts on every accepted command and checks every accepted result.
    always @(posedge aclk) begin
        wheel_t want;
        s_taken = aresetn && s_valid && s_ready;
        if (s_taken) begin
            expected_wheels.push_back(solve_wheels(s_payload));
            beats_sent++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_wheels.size() == 0) begin
                report_mismatch("unexpected result beat", 0, 0);
            end else begin
                want = expected_wheels.pop_front();
                if (m_payload.front_left_speed !== want.front_left_speed)
                    report_mismatch("front_left_speed", m_payload.front_left_speed,
                                    want.front_left_speed);
                if (m_payload.front_right_speed !== want.front_right_speed)
                    report_mismatch("front_right_speed", m_payload.front_right_speed,
                                    want.front_right_speed);
                if (m_payload.back_left_speed !== want.back_left_speed)
                    report_mismatch("back_left_speed", m_payload.back_left_speed,
                                    want.back_left_speed);
                if (m_payload.back_right_speed !== want.back_right_speed)
                    report_mismatch("back_right_speed", m_payload.back_right_speed,
                                    want.back_right_speed);
                if (m_payload.was_scaled !== want.was_scaled)
                    report_mismatch("was_scaled", m_payload.was_scaled, want.was_scaled);
                if (want.was_scaled) scaled_seen++;
            end
            beats_checked++;
        end
    end

    // Register writes happen at the falling edge, one at a time, and only while idle.
    task automatic write_reg(reg_index_t idx, logic [15:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_INVERT_SIDEWAYS: solver_cfg.invert_sideways = value[0];
            REG_INVERT_FORWARD:  solver_cfg.invert_forward  = value[0];
            REG_GEOMETRY_SUM:    solver_cfg.geometry_sum    = value;
            REG_SPEED_LIMIT:     solver_cfg.speed_limit     = value[14:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || s_valid || expected_wheels.size() > 0)
            @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    function automatic cmd_t random_cmd();
        cmd_t c;
        int   sel;
        sel = $urandom_range(0, 9);
        if (sel < 2) begin
            // Edge values stress saturation and the widest sums.
            c.sideways_velocity = ($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'sh7fff;
            c.forward_velocity  = ($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'sh7fff;
            c.yaw_rate          = 16'($urandom);
        end else if (sel < 6) begin
            // Modest commands, so that both scaled and unscaled beats are common.
            c.sideways_velocity = 16'($urandom_range(0, 8000) - 4000);
            c.forward_velocity  = 16'($urandom_range(0, 8000) - 4000);
            c.yaw_rate          = 16'($urandom_range(0, 8000) - 4000);
        end else begin
            c.sideways_velocity = 16'($urandom);
            c.forward_velocity  = 16'($urandom);
            c.yaw_rate          = 16'($urandom);
        end
        return c;
    endfunction

    function automatic cmd_t make_cmd(int vx, int vy, int w);
        cmd_t c;
        c.sideways_velocity = 16'(vx);
        c.forward_velocity  = 16'(vy);
        c.yaw_rate          = 16'(w);
        return c;
    endfunction

    initial begin
        logic [15:0] geom_pick[4];
        logic [15:0] limit_pick[5];
        solver_cfg.invert_sideways = 1'b0;
        solver_cfg.invert_forward  = 1'b0;
        solver_cfg.geometry_sum    = GeometrySumReset;
        solver_cfg.speed_limit     = SpeedLimitReset;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed beats at reset settings: zero command, extremes, the limit boundary.
        pending_cmds.push_back(make_cmd(0, 0, 0));
        pending_cmds.push_back(make_cmd(3072, 0, 0));
        pending_cmds.push_back(make_cmd(3073, 0, 0));
        pending_cmds.push_back(make_cmd(-3072, 0, 0));
        pending_cmds.push_back(make_cmd(0, 1000, 2000));
        pending_cmds.push_back(make_cmd(32767, 32767, 32767));
        pending_cmds.push_back(make_cmd(-32768, -32768, -32768));
        pending_cmds.push_back(make_cmd(-32768, 32767, -1));
        pending_cmds.push_back(make_cmd(1, -1, 1));
        wait_drained();

        // Inversions on, including the saturating negate of the most negative value.
        write_reg(REG_INVERT_SIDEWAYS, 16'd1);
        write_reg(REG_INVERT_FORWARD, 16'd1);
        write_reg(REG_SPEED_LIMIT, 16'd32767);
        pending_cmds.push_back(make_cmd(-32768, -32768, 0));
        pending_cmds.push_back(make_cmd(32767, -32768, 0));
        pending_cmds.push_back(make_cmd(-5, 7, 100));
        wait_drained();

        // Zero limit scales every nonzero wheel to zero; largest geometry sum.
        write_reg(REG_SPEED_LIMIT, 16'd0);
        write_reg(REG_GEOMETRY_SUM, 16'hffff);
        pending_cmds.push_back(make_cmd(0, 0, 0));
        pending_cmds.push_back(make_cmd(1, 0, 0));
        pending_cmds.push_back(make_cmd(-32768, 32767, 32767));
        pending_cmds.push_back(make_cmd(100, -200, -32768));
        wait_drained();

        // Random phases, each under a fresh mix of register settings.
        geom_pick = '{16'd0, 16'd2920, 16'd65535, 16'd1};
        limit_pick = '{16'd0, 16'd1, 16'd3072, 16'd32767, 16'd20000};
        for (int phase = 0; phase < 12; phase++) begin
            write_reg(REG_INVERT_SIDEWAYS, 16'($urandom_range(0, 1)));
            write_reg(REG_INVERT_FORWARD, 16'($urandom_range(0, 1)));
            write_reg(REG_GEOMETRY_SUM, ($urandom_range(0, 1) != 0)
                      ? geom_pick[$urandom_range(0, 3)] : 16'($urandom));
            write_reg(REG_SPEED_LIMIT, ($urandom_range(0, 1) != 0)
                      ? limit_pick[$urandom_range(0, 4)] : 16'($urandom_range(0, 32767)));
            for (int i = 0; i < 150; i++) pending_cmds.push_back(random_cmd());
            if (phase == 5) begin
                // Hold the sender midway until every outstanding result is back.
                while (pending_cmds.size() > 75) @(posedge aclk);
                @(negedge aclk);
                sender_hold = 1'b1;
                while (s_valid || expected_wheels.size() > 0) @(posedge aclk);
                @(negedge aclk);
                sender_hold = 1'b0;
            end
            wait_drained();
        end

        $display("Sent %0d commands over 15 register settings, %0d results checked.",
                 beats_sent, beats_checked);
        $display("%0d results were desaturated; inversions and limit extremes included.",
                 scaled_seen);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
